### src/folt_pkg.sv
// Package for the frequency-ordered lookup table.
// Holds request and result types, opcode and status codes, and control enums.
// No dependencies.
package folt_pkg;

  localparam int DEF_ENTRIES     = 16;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  old_position;
    logic [3:0]  new_position;
    logic [15:0] frequency;
    logic [4:0]  entries_held;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SELECT,
    S_UPDATE
  } ctl_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_MOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     hit;
    logic     below;
  } cell_ctl_t;

endpackage

### src/folt_cell.sv
// One table cell: holds a value and its access count, compares against the key,
// and takes its neighbor's entry when the matched entry moves ahead, or loads the key on append.
// Depends on folt_pkg.
module folt_cell #(
  parameter int INDEX       = 0,
  parameter int COUNT_WIDTH = folt_pkg::DEF_COUNT_WIDTH,
  parameter int NUM_W       = 5
) (
  input  logic                   clk,
  input  folt_pkg::cell_ctl_t    ctl,
  input  logic [31:0]            key,
  input  logic [COUNT_WIDTH-1:0] new_cnt,
  input  logic [NUM_W-1:0]       num,
  input  logic [31:0]            prev_value,
  input  logic [COUNT_WIDTH-1:0] prev_count,
  input  logic                   prev_region,
  output logic [31:0]            value_q,
  output logic [COUNT_WIDTH-1:0] count_q,
  output logic                   match,
  output logic                   region,
  output logic                   dest
);

  logic [31:0]            value_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [31:0]            value_nxt;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic                   active;

  assign active  = NUM_W'(INDEX) < num;
  assign match   = active && (value_r == key);
  assign region  = ctl.hit || (ctl.below && (count_r <= new_cnt));
  assign dest    = region && !prev_region;
  assign value_q = value_r;
  assign count_q = count_r;

  always_comb begin
    value_nxt = value_r;
    count_nxt = count_r;
    case (ctl.op)
      folt_pkg::CELL_APPEND: begin
        if (NUM_W'(INDEX) == num) begin
          value_nxt = key;
          count_nxt = '0;
        end
      end
      folt_pkg::CELL_MOVE: begin
        if (dest) begin
          value_nxt = key;
          count_nxt = new_cnt;
        end else if (region) begin
          value_nxt = prev_value;
          count_nxt = prev_count;
        end
      end
      default: begin
        value_nxt = value_r;
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    count_r <= count_nxt;
  end

endmodule

### src/frequency_ordered_lookup_table.sv
// Top level of the frequency-ordered lookup table: control sequencer and row of cells.
// Depends on folt_pkg and folt_cell.
//
//   channel | signals                     | moves
//   in      | in_valid, in_ready, in_data | request: opcode, value
//   out     | out_valid, out_ready, out_data | result: status, positions, count, size
//
// Each request passes in turn through capture, parallel compare in the cell row,
// count select and increment, then the neighbor shift that moves the entry.
// One request is in flight; the next is taken once the shift is done, even
// while the last result waits in the output register.
// A stalled output holds the sequencer in its shift stage until the register frees.
// Reset clears the sequencer, the output valid and the entry count; cell
// contents are undefined until appended, with no clearing pass.
module frequency_ordered_lookup_table #(
  parameter int ENTRIES     = folt_pkg::DEF_ENTRIES,
  parameter int COUNT_WIDTH = folt_pkg::DEF_COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  folt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output folt_pkg::out_item_t out_data
);

  localparam int NUM_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = $clog2(ENTRIES);

  folt_pkg::ctl_state_t   state_r, state_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [NUM_W-1:0]       num_r, num_nxt;
  logic [ENTRIES-1:0]     hit_oh_r, hit_oh_nxt;
  logic [ENTRIES-1:0]     below_r, below_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       hit_idx_r, hit_idx_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  folt_pkg::out_item_t    out_data_r, out_data_nxt;

  logic [31:0]            cell_value [ENTRIES];
  logic [COUNT_WIDTH-1:0] cell_count [ENTRIES];
  logic [ENTRIES-1:0]     cell_match;
  logic [ENTRIES-1:0]     cell_region;
  logic [ENTRIES-1:0]     cell_dest;
  folt_pkg::cell_op_t     cell_op;
  logic                   advance;
  logic [COUNT_WIDTH-1:0] cnt_sel;
  logic [IDX_W-1:0]       dest_idx;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      folt_pkg::cell_ctl_t    ctl;
      logic [31:0]            prev_value;
      logic [COUNT_WIDTH-1:0] prev_count;
      logic                   prev_region;

      assign ctl.op    = cell_op;
      assign ctl.hit   = hit_oh_r[g];
      assign ctl.below = below_r[g];

      if (g == 0) begin : g_head
        assign prev_value  = '0;
        assign prev_count  = '0;
        assign prev_region = 1'b0;
      end else begin : g_body
        assign prev_value  = cell_value[g-1];
        assign prev_count  = cell_count[g-1];
        assign prev_region = cell_region[g-1];
      end

      folt_cell #(
        .INDEX      (g),
        .COUNT_WIDTH(COUNT_WIDTH),
        .NUM_W      (NUM_W)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .key        (key_r),
        .new_cnt    (cnt_r),
        .num        (num_r),
        .prev_value (prev_value),
        .prev_count (prev_count),
        .prev_region(prev_region),
        .value_q    (cell_value[g]),
        .count_q    (cell_count[g]),
        .match      (cell_match[g]),
        .region     (cell_region[g]),
        .dest       (cell_dest[g])
      );
    end
  endgenerate

  assign in_ready  = (state_r == folt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign advance   = (state_r == folt_pkg::S_UPDATE) && (!out_valid_r || out_ready);

  always_comb begin
    cnt_sel     = '0;
    hit_idx_nxt = '0;
    dest_idx    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh_r[i]) begin
        cnt_sel     = cnt_sel | cell_count[i];
        hit_idx_nxt = hit_idx_nxt | IDX_W'(i);
      end
      if (cell_dest[i]) begin
        dest_idx = dest_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    num_nxt       = num_r;
    hit_oh_nxt    = hit_oh_r;
    below_nxt     = below_r;
    found_nxt     = found_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cell_op       = folt_pkg::CELL_HOLD;

    case (state_r)
      folt_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          key_nxt   = in_data.value;
          state_nxt = folt_pkg::S_MATCH;
        end
      end
      folt_pkg::S_MATCH: begin
        hit_oh_nxt = cell_match & (~cell_match + ENTRIES'(1));
        found_nxt  = |cell_match;
        state_nxt  = folt_pkg::S_SELECT;
      end
      folt_pkg::S_SELECT: begin
        below_nxt = hit_oh_r - ENTRIES'(1);
        cnt_nxt   = (cnt_sel == '1) ? cnt_sel : cnt_sel + COUNT_WIDTH'(1);
        if (!found_r || (op_r != folt_pkg::OP_LOCATE)) begin
          hit_oh_nxt = '0;
          below_nxt  = '0;
        end
        state_nxt = folt_pkg::S_UPDATE;
      end
      folt_pkg::S_UPDATE: begin
        if (advance) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = folt_pkg::ST_DONE;
          out_data_nxt.old_position = '0;
          out_data_nxt.new_position = '0;
          out_data_nxt.frequency    = '0;
          case (op_r)
            folt_pkg::OP_CLEAR: begin
              num_nxt = '0;
            end
            folt_pkg::OP_APPEND: begin
              if (num_r < NUM_W'(ENTRIES)) begin
                cell_op                   = folt_pkg::CELL_APPEND;
                num_nxt                   = num_r + NUM_W'(1);
                out_data_nxt.old_position = 4'(num_r);
                out_data_nxt.new_position = 4'(num_r);
              end else begin
                out_data_nxt.status = folt_pkg::ST_FULL;
              end
            end
            folt_pkg::OP_LOCATE: begin
              if (found_r) begin
                cell_op                   = folt_pkg::CELL_MOVE;
                out_data_nxt.old_position = 4'(hit_idx_r);
                out_data_nxt.new_position = 4'(dest_idx);
                out_data_nxt.frequency    = 16'(cnt_r);
              end else begin
                out_data_nxt.status = folt_pkg::ST_MISS;
              end
            end
            default: begin
              out_data_nxt.status = folt_pkg::ST_DONE;
            end
          endcase
          out_data_nxt.entries_held = 5'(num_nxt);
          state_nxt                 = folt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = folt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= folt_pkg::S_IDLE;
      num_r       <= '0;
      out_valid_r <= 1'b0;
      hit_oh_r    <= '0;
      below_r     <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_r       <= num_nxt;
      out_valid_r <= out_valid_nxt;
      hit_oh_r    <= hit_oh_nxt;
      below_r     <= below_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    cnt_r      <= cnt_nxt;
    hit_idx_r  <= (state_r == folt_pkg::S_SELECT) ? hit_idx_nxt : hit_idx_r;
    out_data_r <= out_data_nxt;
  end

endmodule

### src/folt_checker.sv
// Port-level checker for the frequency-ordered lookup table, bound to the top level.
// Depends on folt_pkg and frequency_ordered_lookup_table.
module folt_checker #(
  parameter int ENTRIES = folt_pkg::DEF_ENTRIES
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input folt_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == folt_pkg::ST_MISS) |->
      (out_data.old_position == 4'd0) && (out_data.new_position == 4'd0) &&
      (out_data.frequency == 16'd0))
    else $error("miss result carries position or count");

  a_full_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == folt_pkg::ST_FULL) |->
      out_data.entries_held == 5'(ENTRIES))
    else $error("full status with table not full");

  a_move_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == folt_pkg::ST_DONE) && (ENTRIES <= 16) |->
      out_data.new_position <= out_data.old_position)
    else $error("entry moved backward");

endmodule

bind frequency_ordered_lookup_table folt_checker #(.ENTRIES(ENTRIES)) u_folt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

### tb/sv/frequency_ordered_lookup_table_test.sv
// Self-checking test of frequency_ordered_lookup_table: directed corners, random sessions.
// Holds a scoreboard class that predicts each result from a private copy of the table.
// Depends on folt_pkg and the frequency_ordered_lookup_table RTL.
module frequency_ordered_lookup_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS           = folt_pkg::DEF_ENTRIES;
  localparam int COUNT_W         = folt_pkg::DEF_COUNT_WIDTH;
  localparam int RANDOM_REQUESTS = 1950;
  localparam int LONG_HOLD       = 80;
  localparam int CYCLE_LIMIT     = 400_000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class table_tracker;
    logic [31:0]         vals[SLOTS];
    logic [COUNT_W-1:0]  cnts[SLOTS];
    int unsigned         held;
    folt_pkg::out_item_t due_results[$];
    int unsigned         errors, results_seen, hits, misses, fulls, top_seen;

    function folt_pkg::out_item_t rank_lookup(folt_pkg::in_item_t r);
      folt_pkg::out_item_t res;
      int                  hit, dest;
      logic [31:0]         v;
      logic [COUNT_W-1:0]  c;
      res = '0;
      hit = -1;
      case (r.opcode)
        folt_pkg::OP_CLEAR: held = 0;
        folt_pkg::OP_APPEND: begin
          if (held >= SLOTS) begin
            res.status = folt_pkg::ST_FULL;
            fulls++;
          end else begin
            vals[held] = r.value;
            cnts[held] = '0;
            res.old_position = 4'(held);
            res.new_position = 4'(held);
            held++;
          end
        end
        folt_pkg::OP_LOCATE: begin
          for (int i = 0; i < held; i++)
            if (hit < 0 && vals[i] == r.value) hit = i;
          if (hit < 0) begin
            res.status = folt_pkg::ST_MISS;
            misses++;
          end else begin
            c = cnts[hit];
            if (c != '1) c = c + 1'b1;
            v = vals[hit];
            dest = hit;
            while (dest > 0 && cnts[dest-1] <= c) dest--;
            for (int i = hit; i > dest; i--) begin
              vals[i] = vals[i-1];
              cnts[i] = cnts[i-1];
            end
            vals[dest] = v;
            cnts[dest] = c;
            res.old_position = 4'(hit);
            res.new_position = 4'(dest);
            res.frequency    = 16'(c);
            hits++;
            if (32'(c) > top_seen) top_seen = 32'(c);
          end
        end
        default: ;
      endcase
      res.entries_held = 5'(held);
      return res;
    endfunction

    function void note_request(folt_pkg::in_item_t r);
      due_results.push_back(rank_lookup(r));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
      end
    endfunction

    function void check_result(folt_pkg::out_item_t got);
      folt_pkg::out_item_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result expected none, got %p", $time, got);
        return;
      end
      want = due_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("old_position", 32'(want.old_position), 32'(got.old_position));
      compare_field("new_position", 32'(want.new_position), 32'(got.new_position));
      compare_field("frequency", 32'(want.frequency), 32'(got.frequency));
      compare_field("entries_held", 32'(want.entries_held), 32'(got.entries_held));
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  folt_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  folt_pkg::out_item_t out_data;

  table_tracker board = new();
  int unsigned  sent;
  int unsigned  cycles;
  int           hold_left;
  bit           long_hold_req;
  bit           calm;
  logic [31:0]  pool[$];

  logic [31:0] corner_values[SLOTS] = '{
    32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
    32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0000,
    32'h0000_0002, 32'h0000_0003, 32'hffff_fffe, 32'h1234_5678,
    32'h8000_0001, 32'h7fff_fffe, 32'h0f0f_0f0f, 32'hf0f0_f0f0
  };

  frequency_ordered_lookup_table #(
    .ENTRIES    (SLOTS),
    .COUNT_WIDTH(COUNT_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check_result(out_data);
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_request(logic [1:0] op, logic [31:0] val);
    folt_pkg::in_item_t r;
    r.opcode = op;
    r.value  = val;
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(r);
    sent++;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return 32'($urandom_range(0, 7)) - 32'd4;
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  initial begin
    int unsigned random_goal;
    int          fill, ops, pick;
    bit          held_long, paused;
    logic [31:0] v;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_request(folt_pkg::OP_LOCATE, 32'h0000_0005);
    push_request(OP_UNUSED, 32'hffff_ffff);
    foreach (corner_values[i]) push_request(folt_pkg::OP_APPEND, corner_values[i]);
    push_request(folt_pkg::OP_APPEND, 32'hdead_beef);
    push_request(folt_pkg::OP_LOCATE, 32'hffff_ffff);
    push_request(folt_pkg::OP_LOCATE, 32'h0000_0000);
    push_request(folt_pkg::OP_LOCATE, 32'h0000_0000);
    push_request(folt_pkg::OP_LOCATE, 32'h7fff_ffff);
    push_request(folt_pkg::OP_LOCATE, 32'h1357_9bdf);
    push_request(OP_UNUSED, 32'h0000_0000);
    push_request(folt_pkg::OP_CLEAR, 32'h0000_0000);
    push_request(folt_pkg::OP_LOCATE, 32'h0000_0000);

    random_goal = sent + RANDOM_REQUESTS;
    while (sent < random_goal) begin
      if (!held_long && sent >= 600) begin
        held_long = 1'b1;
        long_hold_req = 1'b1;
      end
      if (!paused && sent >= 1200) begin
        paused = 1'b1;
        drain();
        @(negedge clk);
      end
      if ($urandom_range(0, 4) != 0) begin
        push_request(folt_pkg::OP_CLEAR, $urandom);
        pool.delete();
      end
      fill = $urandom_range(1, SLOTS);
      if ($urandom_range(0, 3) == 0) fill += $urandom_range(1, 3);
      repeat (fill) begin
        v = pick_value();
        push_request(folt_pkg::OP_APPEND, v);
        if (pool.size() < SLOTS) pool.push_back(v);
      end
      ops = $urandom_range(20, 120);
      repeat (ops) begin
        pick = $urandom_range(0, 99);
        if (pick < 85 && pool.size() != 0) begin
          if ($urandom_range(0, 9) < 4)
            v = pool[$urandom_range(0, (pool.size() < 4 ? pool.size() : 4) - 1)];
          else
            v = pool[$urandom_range(0, pool.size() - 1)];
          push_request(folt_pkg::OP_LOCATE, v);
        end else if (pick < 95) begin
          push_request(folt_pkg::OP_LOCATE, $urandom);
        end else begin
          v = pick_value();
          push_request(folt_pkg::OP_APPEND, v);
          if (pool.size() < SLOTS) pool.push_back(v);
        end
      end
    end

    calm = 1'b1;
    push_request(folt_pkg::OP_CLEAR, 32'h0000_0000);
    push_request(folt_pkg::OP_APPEND, 32'h600d_0001);
    push_request(folt_pkg::OP_APPEND, 32'h600d_0002);
    repeat (6) push_request(folt_pkg::OP_LOCATE, 32'h600d_0001);
    repeat (8) push_request(folt_pkg::OP_LOCATE, 32'h600d_0002);
    push_request(folt_pkg::OP_LOCATE, 32'h600d_0001);

    drain();
    repeat (12) @(negedge clk);
    $display("Sent %0d requests: %0d locate hits, %0d misses, %0d appends to a full table.",
             sent, board.hits, board.misses, board.fulls);
    $display("Checked %0d results, highest count reached %0d, %0d mismatches.",
             board.results_seen, board.top_seen, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
